/* hw/rtl/mwoc_pkg.sv */
package mwoc_pkg;

    typedef enum logic [3:0] {
        EV_CLOCK   = 4'd0,
        EV_POWER   = 4'd1,
        EV_MODE    = 4'd2,
        EV_DEFROST = 4'd3,
        EV_START   = 4'd4,
        EV_STOP    = 4'd5,
        EV_DIAL    = 4'd6,
        EV_SECOND  = 4'd7,
        EV_MINUTE  = 4'd8,
        EV_NONE    = 4'd15
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_HOURS    = 3'd1,
        ST_MINUTES  = 3'd2,
        ST_POWER    = 3'd3,
        ST_DURATION = 3'd4,
        ST_HEAT     = 3'd5,
        ST_DEFROST  = 3'd6,
        ST_COOKING  = 3'd7
    } ui_state_t;

    typedef enum logic [2:0] {
        DK_TIME     = 3'd0,
        DK_HOURS    = 3'd1,
        DK_MINUTES  = 3'd2,
        DK_POWER    = 3'd3,
        DK_DURATION = 3'd4,
        DK_GRAMS    = 3'd5,
        DK_HEAT     = 3'd6,
        DK_FINISHED = 3'd7
    } disp_kind_t;

    localparam logic [1:0]  HM_MICROWAVE   = 2'd0;
    localparam logic [1:0]  HM_GRILL       = 2'd1;
    localparam logic [1:0]  HM_COMBINED    = 2'd2;
    localparam logic [6:0]  DIAL_MAX       = 7'd99;
    localparam logic [6:0]  FULL_POWER     = 7'd100;
    localparam logic [12:0] START_DURATION = 13'd60;
    localparam logic [12:0] MAX_DURATION   = 13'd5999;
    localparam logic [12:0] DEFROST_GRAMS  = 13'd100;
    localparam logic [5:0]  MINUTE_LAST    = 6'd59;
    localparam logic [4:0]  HOUR_LAST      = 5'd23;
    localparam logic [12:0] MINUTES_PER_HOUR = 13'd60;

    typedef struct packed {
        logic [3:0] mode;
        logic [6:0] dial_value;
    } request_t;

    typedef struct packed {
        logic [2:0]  ui_state;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [6:0]  power_percent;
        logic [12:0] duration_seconds;
        logic [1:0]  heat_mode;
        logic        finished;
        logic [2:0]  display_kind;
        logic [12:0] display_value;
    } result_t;

    // Decoded event with every dial mapping worked out ahead of the state lookup.
    typedef struct packed {
        event_t      ev;
        logic [4:0]  hour_val;
        logic [5:0]  minute_val;
        logic [6:0]  power_val;
        logic [10:0] dial_dur;
        logic [7:0]  defrost_dur;
        logic [1:0]  heat_val;
        logic [12:0] grams;
    } command_t;

endpackage

/* hw/rtl/mwoc_front.sv */
module mwoc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mwoc_pkg::request_t  s_payload,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output mwoc_pkg::command_t  cmd
);

    logic               valid_reg, valid_next;
    mwoc_pkg::command_t cmd_reg, cmd_next;

    logic [6:0]  pos;
    logic [14:0] hour_prod;
    logic [15:0] minute_prod;
    logic [8:0]  defrost_prod;
    mwoc_pkg::event_t ev;

    assign pos = (s_payload.dial_value > mwoc_pkg::DIAL_MAX) ? mwoc_pkg::DIAL_MAX
                                                               : s_payload.dial_value;

    // pos*24/100 and pos*60/100 as multiplications by scaled reciprocals;
    // the error stays below one unit over the whole dial range.
    assign hour_prod    = 15'(pos) * 15'd246;
    assign minute_prod  = 16'(pos) * 16'd615;
    assign defrost_prod = 9'(pos) * 9'd5;

    always_comb begin
        unique case (s_payload.mode)
            mwoc_pkg::EV_CLOCK:   ev = mwoc_pkg::EV_CLOCK;
            mwoc_pkg::EV_POWER:   ev = mwoc_pkg::EV_POWER;
            mwoc_pkg::EV_MODE:    ev = mwoc_pkg::EV_MODE;
            mwoc_pkg::EV_DEFROST: ev = mwoc_pkg::EV_DEFROST;
            mwoc_pkg::EV_START:   ev = mwoc_pkg::EV_START;
            mwoc_pkg::EV_STOP:    ev = mwoc_pkg::EV_STOP;
            mwoc_pkg::EV_DIAL:    ev = mwoc_pkg::EV_DIAL;
            mwoc_pkg::EV_SECOND:  ev = mwoc_pkg::EV_SECOND;
            mwoc_pkg::EV_MINUTE:  ev = mwoc_pkg::EV_MINUTE;
            default:              ev = mwoc_pkg::EV_NONE;
        endcase
    end

    always_comb begin
        cmd_next.ev          = ev;
        cmd_next.hour_val    = hour_prod[14:10];
        cmd_next.minute_val  = minute_prod[15:10];
        cmd_next.power_val   = pos + 7'd1;
        cmd_next.dial_dur    = 11'(pos) * 11'd15;
        cmd_next.defrost_dur = defrost_prod[8:1];
        cmd_next.grams       = 13'(pos) * 13'd50;
        if (pos >= 7'd98) begin
            cmd_next.heat_val = mwoc_pkg::HM_COMBINED;
        end else if (pos >= 7'd49) begin
            cmd_next.heat_val = mwoc_pkg::HM_GRILL;
        end else begin
            cmd_next.heat_val = mwoc_pkg::HM_MICROWAVE;
        end
    end

    assign s_ready    = !valid_reg || cmd_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* hw/rtl/mwoc_queue.sv */
module mwoc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mwoc_pkg::command_t  in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output mwoc_pkg::command_t  out_cmd
);

    mwoc_pkg::command_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign out_cmd = entry_reg[rd_ptr_reg];

endmodule

/* hw/rtl/mwoc_exec.sv */
module mwoc_exec (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mwoc_pkg::command_t  cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output mwoc_pkg::result_t   m_payload
);

    mwoc_pkg::ui_state_t ui_state_reg, ui_state_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [6:0]  power_reg, power_next;
    logic [12:0] duration_reg, duration_next;
    logic [1:0]  heat_mode_reg, heat_mode_next;
    logic        finished_reg, finished_next;

    logic              m_valid_reg, m_valid_next;
    mwoc_pkg::result_t m_payload_reg, m_payload_next;

    logic        fire;
    logic [12:0] dur_added;
    logic        grams_shown;
    mwoc_pkg::disp_kind_t kind;
    logic [12:0] value;

    assign fire      = cmd_valid && (!m_valid_reg || m_ready);
    assign cmd_ready = !m_valid_reg || m_ready;
    assign dur_added = duration_reg + mwoc_pkg::START_DURATION;

    // Next state of the user-interface machine.
    always_comb begin
        ui_state_next = ui_state_reg;
        unique case (cmd.ev)
            mwoc_pkg::EV_CLOCK: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    ui_state_next = mwoc_pkg::ST_HOURS;
                end else if (ui_state_reg == mwoc_pkg::ST_HOURS) begin
                    ui_state_next = mwoc_pkg::ST_MINUTES;
                end else if (ui_state_reg == mwoc_pkg::ST_MINUTES) begin
                    ui_state_next = mwoc_pkg::ST_IDLE;
                end
            end
            mwoc_pkg::EV_POWER: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    ui_state_next = mwoc_pkg::ST_POWER;
                end else if (ui_state_reg == mwoc_pkg::ST_POWER) begin
                    ui_state_next = mwoc_pkg::ST_DURATION;
                end
            end
            mwoc_pkg::EV_MODE: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    ui_state_next = mwoc_pkg::ST_HEAT;
                end else if (ui_state_reg == mwoc_pkg::ST_HEAT) begin
                    ui_state_next = mwoc_pkg::ST_DURATION;
                end
            end
            mwoc_pkg::EV_DEFROST: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    ui_state_next = mwoc_pkg::ST_DEFROST;
                end
            end
            mwoc_pkg::EV_START: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE
                        || ui_state_reg == mwoc_pkg::ST_DURATION
                        || ui_state_reg == mwoc_pkg::ST_DEFROST) begin
                    ui_state_next = mwoc_pkg::ST_COOKING;
                end
            end
            mwoc_pkg::EV_STOP: begin
                ui_state_next = mwoc_pkg::ST_IDLE;
            end
            default: begin
            end
        endcase
    end

    // Clock, power, duration, heat mode and the finished flag.
    always_comb begin
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        power_next     = power_reg;
        duration_next  = duration_reg;
        heat_mode_next = heat_mode_reg;
        finished_next  = finished_reg;
        unique case (cmd.ev)
            mwoc_pkg::EV_MODE: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    heat_mode_next = mwoc_pkg::HM_MICROWAVE;
                end
            end
            mwoc_pkg::EV_START: begin
                if (ui_state_reg == mwoc_pkg::ST_IDLE) begin
                    power_next    = mwoc_pkg::FULL_POWER;
                    duration_next = mwoc_pkg::START_DURATION;
                    finished_next = 1'b0;
                end else if (ui_state_reg == mwoc_pkg::ST_DURATION
                        || ui_state_reg == mwoc_pkg::ST_DEFROST) begin
                    finished_next = 1'b0;
                end else if (ui_state_reg == mwoc_pkg::ST_COOKING) begin
                    duration_next = (dur_added > mwoc_pkg::MAX_DURATION)
                                    ? mwoc_pkg::MAX_DURATION : dur_added;
                    finished_next = 1'b0;
                end
            end
            mwoc_pkg::EV_STOP: begin
                finished_next = 1'b0;
            end
            mwoc_pkg::EV_DIAL: begin
                unique case (ui_state_reg)
                    mwoc_pkg::ST_HOURS:    hour_next      = cmd.hour_val;
                    mwoc_pkg::ST_MINUTES:  minute_next    = cmd.minute_val;
                    mwoc_pkg::ST_POWER:    power_next     = cmd.power_val;
                    mwoc_pkg::ST_DURATION: duration_next  = 13'(cmd.dial_dur);
                    mwoc_pkg::ST_DEFROST:  duration_next  = 13'(cmd.defrost_dur);
                    mwoc_pkg::ST_HEAT:     heat_mode_next = cmd.heat_val;
                    default: begin
                    end
                endcase
            end
            mwoc_pkg::EV_SECOND: begin
                if (ui_state_reg == mwoc_pkg::ST_COOKING) begin
                    if (duration_reg == 13'd0) begin
                        finished_next = 1'b1;
                    end else begin
                        duration_next = duration_reg - 13'd1;
                    end
                end
            end
            mwoc_pkg::EV_MINUTE: begin
                if (ui_state_reg != mwoc_pkg::ST_HOURS
                        && ui_state_reg != mwoc_pkg::ST_MINUTES) begin
                    if (minute_reg >= mwoc_pkg::MINUTE_LAST) begin
                        minute_next = 6'd0;
                        hour_next   = (hour_reg >= mwoc_pkg::HOUR_LAST) ? 5'd0
                                                                        : hour_reg + 5'd1;
                    end else begin
                        minute_next = minute_reg + 6'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Grams are shown on entering defrost and on each dial turn there.
    assign grams_shown = (cmd.ev == mwoc_pkg::EV_DEFROST && ui_state_reg == mwoc_pkg::ST_IDLE)
                      || (cmd.ev == mwoc_pkg::EV_DIAL && ui_state_reg == mwoc_pkg::ST_DEFROST);

    always_comb begin
        unique case (ui_state_next)
            mwoc_pkg::ST_IDLE: begin
                kind  = mwoc_pkg::DK_TIME;
                value = 13'(hour_next) * mwoc_pkg::MINUTES_PER_HOUR + 13'(minute_next);
            end
            mwoc_pkg::ST_HOURS: begin
                kind  = mwoc_pkg::DK_HOURS;
                value = 13'(hour_next);
            end
            mwoc_pkg::ST_MINUTES: begin
                kind  = mwoc_pkg::DK_MINUTES;
                value = 13'(minute_next);
            end
            mwoc_pkg::ST_POWER: begin
                kind  = mwoc_pkg::DK_POWER;
                value = 13'(power_next);
            end
            mwoc_pkg::ST_HEAT: begin
                kind  = mwoc_pkg::DK_HEAT;
                value = 13'(heat_mode_next);
            end
            mwoc_pkg::ST_DEFROST: begin
                if (grams_shown) begin
                    kind  = mwoc_pkg::DK_GRAMS;
                    value = (cmd.ev == mwoc_pkg::EV_DIAL) ? cmd.grams
                                                           : mwoc_pkg::DEFROST_GRAMS;
                end else begin
                    kind  = mwoc_pkg::DK_DURATION;
                    value = duration_next;
                end
            end
            mwoc_pkg::ST_COOKING: begin
                if (finished_next) begin
                    kind  = mwoc_pkg::DK_FINISHED;
                    value = 13'd0;
                end else begin
                    kind  = mwoc_pkg::DK_DURATION;
                    value = duration_next;
                end
            end
            default: begin
                kind  = mwoc_pkg::DK_DURATION;
                value = duration_next;
            end
        endcase
    end

    always_comb begin
        m_payload_next.ui_state         = ui_state_next;
        m_payload_next.clock_hour       = hour_next;
        m_payload_next.clock_minute     = minute_next;
        m_payload_next.power_percent    = power_next;
        m_payload_next.duration_seconds = duration_next;
        m_payload_next.heat_mode        = heat_mode_next;
        m_payload_next.finished         = finished_next;
        m_payload_next.display_kind     = kind;
        m_payload_next.display_value    = value;
    end

    assign m_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ui_state_reg  <= mwoc_pkg::ST_IDLE;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            power_reg     <= mwoc_pkg::FULL_POWER;
            duration_reg  <= mwoc_pkg::START_DURATION;
            heat_mode_reg <= mwoc_pkg::HM_MICROWAVE;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                ui_state_reg  <= ui_state_next;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                power_reg     <= power_next;
                duration_reg  <= duration_next;
                heat_mode_reg <= heat_mode_next;
                finished_reg  <= finished_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* hw/rtl/microwave_oven_controller_unit.sv */
// Microwave oven controller. Every accepted event request (button, dial turn, second or
// minute tick) yields exactly one result: the interface state after the event, the clock,
// power, cook time, heat mode, finished flag and a display kind and value. One request is
// taken per clock cycle in steady state when the consumer does not stall. The accepting
// edge loads the decode register, from which the command moves into the two-entry command
// queue and then into the output register, where its result is offered; a stall can hold
// it at each of these steps. The decoder works out all dial mappings up front, and the
// executing stage applies one command per cycle to the oven state while the output
// register is free. Either side may stall on its own: the queue and the output register
// absorb back-pressure without dropping a request.
module microwave_oven_controller_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mwoc_pkg::request_t s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output mwoc_pkg::result_t  m_payload
);

    logic               dec_valid, dec_ready;
    mwoc_pkg::command_t dec_cmd;
    logic               q_valid, q_ready;
    mwoc_pkg::command_t q_cmd;

    mwoc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (dec_valid),
        .cmd_ready (dec_ready),
        .cmd       (dec_cmd)
    );

    mwoc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_cmd    (dec_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mwoc_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* hw/rtl/mwoc_checker.sv */
module mwoc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input mwoc_pkg::request_t s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input mwoc_pkg::result_t  m_payload
);

    // A request that is not yet taken stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("request changed while waiting");

    // A result held back by the consumer must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // The finished flag can only be up while cooking.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.finished |-> m_payload.ui_state == mwoc_pkg::ST_COOKING)
        else $error("finished shown outside cooking");

    // Cook time never exceeds its ceiling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.duration_seconds <= mwoc_pkg::MAX_DURATION)
        else $error("duration above ceiling");

    // In idle the display shows the time of day as minute of day.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.ui_state == mwoc_pkg::ST_IDLE
        |-> m_payload.display_kind == mwoc_pkg::DK_TIME
            && m_payload.display_value == 13'(m_payload.clock_hour) * 13'd60
                                          + 13'(m_payload.clock_minute))
        else $error("idle display does not show the clock");

endmodule

bind microwave_oven_controller_unit mwoc_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
